// ===== rtl/itoa_pkg.sv =====
// shared constants, types and helpers for the integer to ascii converter
package itoa_pkg;

	localparam int VALUE_BITS = 64;
	localparam int MAX_CHARS  = 64;

	localparam int IN_VALUE_W = 64;
	localparam int RADIX_W    = 6;
	localparam int CHAR_W     = 7;
	localparam int DIGIT_W    = 6;

	localparam int BIT_CNT_W  = $clog2(VALUE_BITS);
	localparam int DIG_CNT_W  = $clog2(VALUE_BITS + 1);
	localparam int CHAR_CNT_W = $clog2(((VALUE_BITS > MAX_CHARS) ? VALUE_BITS : MAX_CHARS) + 2);

	localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
	localparam logic [RADIX_W-1:0] RADIX_DEC = RADIX_W'(10);

	localparam logic [CHAR_W-1:0] CH_ZERO  = CHAR_W'(8'h30);
	localparam logic [CHAR_W-1:0] CH_A     = CHAR_W'(8'h61);
	localparam logic [CHAR_W-1:0] CH_MINUS = CHAR_W'(8'h2d);

	localparam logic [DIGIT_W-1:0] DIGIT_NINE = DIGIT_W'(9);
	localparam logic [DIGIT_W-1:0] DIGIT_TEN  = DIGIT_W'(10);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

	function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d > DIGIT_NINE) begin
			c = CH_A + CHAR_W'(d - DIGIT_TEN);
		end else begin
			c = CH_ZERO + CHAR_W'(d);
		end
		return c;
	endfunction

endpackage

// ===== rtl/itoa_in_if.sv =====
// input channel: one number with its mode and radix
interface itoa_in_if;
	import itoa_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  mode;
	logic [IN_VALUE_W-1:0] value;
	logic [RADIX_W-1:0]    radix;

	modport source (output valid, output mode, output value, output radix, input ready);
	modport sink   (input valid, input mode, input value, input radix, output ready);
endinterface

// ===== rtl/itoa_out_if.sv =====
// output channel: one ascii character with its end marker
interface itoa_out_if;
	import itoa_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              last;

	modport source (output valid, output char_code, output last, input ready);
	modport sink   (input valid, input char_code, input last, output ready);
endinterface

// ===== rtl/integer_to_ascii_radix.sv =====
// Converts a 64-bit number to ASCII digits in radix 2..36, most significant first, last marked.
// A number is taken only while the block is idle. Each digit comes from a serial restoring
// division by the radix through one shared 7-bit subtract/compare unit, one quotient bit per
// cycle, and each digit takes a pass over all VALUE_BITS (64) bits of the value; characters
// then leave at one per cycle when the sink is ready. The longest output is 64 binary digits.
// The final character sits in an output register, so the next number may be taken while
// that character still waits. In signed mode with radix 10 a negative number is printed as
// '-' and its magnitude; radix codes below 2 act as 2 and above 36 act as 36.
module integer_to_ascii_radix (
	input  logic       clk,
	input  logic       arst_n,
	itoa_in_if.sink    num,
	itoa_out_if.source chr
);
	import itoa_pkg::*;

	state_t state_q, state_d;

	logic [VALUE_BITS-1:0] val_q;
	logic [DIGIT_W-1:0]    rem_q;
	logic [RADIX_W-1:0]    radix_q;
	logic [BIT_CNT_W-1:0]  bit_cnt_q;
	logic [DIG_CNT_W-1:0]  ndig_q;
	logic                  neg_q;
	logic [CHAR_CNT_W-1:0] chars_left_q;
	logic [DIGIT_W-1:0]    dig_q [VALUE_BITS];
	logic                  out_valid_q;
	logic [CHAR_W-1:0]     out_char_q;
	logic                  out_last_q;

	// input decode
	logic [VALUE_BITS-1:0] in_val;
	logic [RADIX_W-1:0]    in_radix;
	logic                  in_neg;

	// shared divide step
	logic [DIGIT_W:0]      trial;
	logic                  q_bit;
	logic [DIGIT_W-1:0]    rem_next;
	logic [VALUE_BITS-1:0] val_next;
	logic                  bit_last;
	logic [CHAR_CNT_W-1:0] total_chars;
	logic [CHAR_CNT_W-1:0] clamp_chars;

	// control
	logic accept;
	logic digit_done;
	logic div_finish;
	logic load_out;
	logic [CHAR_W-1:0] next_char;

	always_comb begin
		if (num.radix inside {[0:1]}) begin
			in_radix = RADIX_MIN;
		end else if (num.radix > RADIX_MAX) begin
			in_radix = RADIX_MAX;
		end else begin
			in_radix = num.radix;
		end
		in_neg = num.mode && (in_radix == RADIX_DEC) && num.value[VALUE_BITS-1];
		in_val = in_neg ? (~num.value[VALUE_BITS-1:0] + VALUE_BITS'(1))
		                : num.value[VALUE_BITS-1:0];
	end

	always_comb begin
		trial    = {rem_q, val_q[VALUE_BITS-1]};
		q_bit    = trial >= {1'b0, radix_q};
		rem_next = q_bit ? DIGIT_W'(trial - {1'b0, radix_q}) : DIGIT_W'(trial);
		val_next = {val_q[VALUE_BITS-2:0], q_bit};
		bit_last = bit_cnt_q == BIT_CNT_W'(VALUE_BITS - 1);
		total_chars = CHAR_CNT_W'(ndig_q) + CHAR_CNT_W'(1) + CHAR_CNT_W'(neg_q);
		clamp_chars = (total_chars > CHAR_CNT_W'(MAX_CHARS)) ? CHAR_CNT_W'(MAX_CHARS)
		                                                     : total_chars;
		next_char = neg_q ? CH_MINUS : digit_to_char(dig_q[0]);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (num.valid) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (bit_last && (val_next == '0)) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (load_out && (chars_left_q == CHAR_CNT_W'(1))) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and datapath controls
	always_comb begin
		num.ready     = state_q == ST_IDLE;
		accept        = (state_q == ST_IDLE) && num.valid;
		digit_done    = (state_q == ST_DIV) && bit_last;
		div_finish    = digit_done && (val_next == '0);
		load_out      = (state_q == ST_EMIT) && (!out_valid_q || chr.ready);
		chr.valid     = out_valid_q;
		chr.char_code = out_char_q;
		chr.last      = out_last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (chr.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val_q     <= in_val;
			radix_q   <= in_radix;
			neg_q     <= in_neg;
			rem_q     <= '0;
			bit_cnt_q <= '0;
			ndig_q    <= '0;
		end else if (state_q == ST_DIV) begin
			val_q <= val_next;
			if (digit_done) begin
				// remainder is the next digit, push it on the digit stack
				rem_q     <= '0;
				bit_cnt_q <= '0;
				ndig_q    <= ndig_q + DIG_CNT_W'(1);
				dig_q[0]  <= rem_next;
				for (int i = 1; i < VALUE_BITS; i++) begin
					dig_q[i] <= dig_q[i-1];
				end
				if (div_finish) begin
					chars_left_q <= clamp_chars;
				end
			end else begin
				rem_q     <= rem_next;
				bit_cnt_q <= bit_cnt_q + BIT_CNT_W'(1);
			end
		end else if (load_out) begin
			out_char_q   <= next_char;
			out_last_q   <= chars_left_q == CHAR_CNT_W'(1);
			chars_left_q <= chars_left_q - CHAR_CNT_W'(1);
			if (neg_q) begin
				neg_q <= 1'b0;
			end else begin
				for (int i = 0; i < VALUE_BITS - 1; i++) begin
					dig_q[i] <= dig_q[i+1];
				end
			end
		end
	end

	// partial remainder must stay below the divisor
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < radix_q))
		else $error("partial remainder not below radix");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> ((radix_q >= RADIX_MIN) && (radix_q <= RADIX_MAX)))
		else $error("radix out of range during division");

	// emission always has a character left to send
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (chars_left_q != '0))
		else $error("emit phase with no characters left");

	assert property (@(posedge clk) disable iff (!arst_n)
		(chr.valid && chr.last) |-> (state_q != ST_EMIT || !$past(load_out) || neg_q == 1'b0))
		else $error("last character sent before sign");

endmodule

// ===== sim/integer_to_ascii_radix_tb.sv =====
// testbench for integer_to_ascii_radix: queued numbers, random handshakes, predicted characters
`timescale 1ns / 100ps

module integer_to_ascii_radix_tb;
	import itoa_pkg::*;

	localparam int STALL_LIMIT    = 25000;
	localparam int TAIL_CYCLES    = 300;
	localparam int RANDOM_NUMBERS = 115;
	localparam int REPORT_LIMIT   = 100;

	typedef struct {
		logic                  mode;
		logic [IN_VALUE_W-1:0] value;
		logic [RADIX_W-1:0]    radix;
		int                    gap;
		bit                    drain;
	} number_t;

	typedef struct {
		logic [CHAR_W-1:0] char_code;
		logic              last;
	} ascii_char_t;

	logic clk = 1'b0;
	logic arst_n;

	itoa_in_if  num_if ();
	itoa_out_if chr_if ();

	integer_to_ascii_radix u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (num_if),
		.chr    (chr_if)
	);

	number_t     numbers_to_send[$];
	ascii_char_t pending_chars[$];

	int error_count;
	int numbers_queued;
	int numbers_done;
	int chars_done;
	int neg_decimal_done;
	int odd_radix_done;
	int send_wait;
	int recv_wait;
	int recv_quiet;
	int recv_draw;
	int idle_cycles;
	bit fill_burst;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// expected characters of one number, most significant first
	function automatic void expand_number(input logic mode, input logic [IN_VALUE_W-1:0] value,
			input logic [RADIX_W-1:0] radix);
		logic [63:0]       mask;
		logic [63:0]       mag;
		logic [63:0]       base;
		logic [63:0]       digit;
		logic [CHAR_W-1:0] text[$];
		bit                neg;
		int                keep;
		int                k;
		ascii_char_t       c;
		mask = '1;
		if (VALUE_BITS < 64)
			mask = (64'd1 << VALUE_BITS) - 64'd1;
		mag = value & mask;
		base = 64'(radix);
		if (base < 64'(RADIX_MIN))
			base = 64'(RADIX_MIN);
		if (base > 64'(RADIX_MAX))
			base = 64'(RADIX_MAX);
		neg = 1'b0;
		// only decimal gets a minus sign, other bases print the raw pattern
		if (mode && base == 64'(RADIX_DEC) && mag[VALUE_BITS-1]) begin
			neg = 1'b1;
			mag = (~mag + 64'd1) & mask;
		end
		if (mag == 64'd0)
			text.push_front(CH_ZERO);
		while (mag != 64'd0) begin
			digit = mag % base;
			if (digit > 64'(DIGIT_NINE))
				text.push_front(CH_A + CHAR_W'(digit - 64'(DIGIT_TEN)));
			else
				text.push_front(CH_ZERO + CHAR_W'(digit));
			mag = mag / base;
		end
		if (neg)
			text.push_front(CH_MINUS);
		keep = (MAX_CHARS > 64) ? 64 : ((MAX_CHARS < 1) ? 1 : MAX_CHARS);
		if (text.size() < keep)
			keep = text.size();
		for (k = 0; k < keep; k++) begin
			c.char_code = text[k];
			c.last = (k == keep - 1);
			pending_chars.push_back(c);
		end
	endfunction

	task automatic add_number(input logic mode, input logic [IN_VALUE_W-1:0] value,
			input logic [RADIX_W-1:0] radix, input bit drain);
		number_t entry;
		entry.mode = mode;
		entry.value = value;
		entry.radix = radix;
		entry.gap = fill_burst ? 0 : $urandom_range(0, 12);
		entry.drain = drain;
		numbers_to_send.push_back(entry);
		numbers_queued++;
	endtask

	// number driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_if.valid <= 1'b0;
			num_if.mode <= 1'b0;
			num_if.value <= '0;
			num_if.radix <= '0;
			send_wait <= 0;
		end else begin
			if (num_if.valid && num_if.ready) begin
				expand_number(num_if.mode, num_if.value, num_if.radix);
				numbers_done++;
				if (num_if.mode && num_if.radix == RADIX_DEC && num_if.value[VALUE_BITS-1])
					neg_decimal_done++;
				if (num_if.radix < RADIX_MIN || num_if.radix > RADIX_MAX)
					odd_radix_done++;
			end
			if (!num_if.valid || num_if.ready) begin
				if (numbers_to_send.size() == 0) begin
					num_if.valid <= 1'b0;
				end else if (numbers_to_send[0].drain && pending_chars.size() != 0) begin
					// hold off until every character in flight has come out
					num_if.valid <= 1'b0;
				end else if (send_wait < numbers_to_send[0].gap) begin
					send_wait <= send_wait + 1;
					num_if.valid <= 1'b0;
				end else begin
					num_if.valid <= 1'b1;
					num_if.mode <= numbers_to_send[0].mode;
					num_if.value <= numbers_to_send[0].value;
					num_if.radix <= numbers_to_send[0].radix;
					numbers_to_send.delete(0);
					send_wait <= 0;
				end
			end
		end
	end

	// character monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chr_if.ready <= 1'b0;
			recv_wait <= 0;
			recv_quiet = 0;
		end else if (chr_if.valid && chr_if.ready) begin
			if (pending_chars.size() == 0) begin
				error_count++;
				if (error_count <= REPORT_LIMIT)
					$display("%0t: unexpected transaction, char %h last %b", $time,
						chr_if.char_code, chr_if.last);
			end else begin
				if (chr_if.char_code !== pending_chars[0].char_code) begin
					error_count++;
					if (error_count <= REPORT_LIMIT)
						$display("%0t: char_code expected %h actual %h", $time,
							pending_chars[0].char_code, chr_if.char_code);
				end
				if (chr_if.last !== pending_chars[0].last) begin
					error_count++;
					if (error_count <= REPORT_LIMIT)
						$display("%0t: last expected %b actual %b", $time,
							pending_chars[0].last, chr_if.last);
				end
				pending_chars.delete(0);
				chars_done++;
			end
			// occasional quiet stretch where the sink never stalls
			if (recv_quiet > 0) begin
				recv_draw = 0;
				recv_quiet = recv_quiet - 1;
			end else if ($urandom_range(0, 9) == 0) begin
				recv_draw = 0;
				recv_quiet = 40;
			end else begin
				recv_draw = $urandom_range(0, 12);
			end
			recv_wait <= recv_draw;
			chr_if.ready <= (recv_draw == 0);
		end else if (recv_wait > 0) begin
			recv_wait <= recv_wait - 1;
			chr_if.ready <= (recv_wait == 1);
		end else begin
			chr_if.ready <= 1'b1;
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (num_if.valid && num_if.ready) || (chr_if.valid && chr_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int                 i;
		logic [63:0]        v;
		logic [RADIX_W-1:0] r;
		logic               m;
		arst_n = 1'b0;
		num_if.valid = 1'b0;
		num_if.mode = 1'b0;
		num_if.value = '0;
		num_if.radix = '0;
		chr_if.ready = 1'b0;
		fill_burst = 1'b0;

		// zero, extremes, sign handling and radix clamping
		add_number(1'b0, 64'd0, RADIX_DEC, 1'b0);
		add_number(1'b0, 64'd0, RADIX_MIN, 1'b0);
		add_number(1'b1, 64'd0, RADIX_DEC, 1'b0);
		add_number(1'b0, 64'd1, RADIX_MIN, 1'b0);
		add_number(1'b0, '1, RADIX_MIN, 1'b0);
		add_number(1'b0, '1, RADIX_MAX, 1'b0);
		add_number(1'b0, '1, RADIX_DEC, 1'b0);
		add_number(1'b1, 64'h8000_0000_0000_0000, RADIX_DEC, 1'b0);
		add_number(1'b1, '1, RADIX_DEC, 1'b0);
		add_number(1'b1, 64'h7fff_ffff_ffff_ffff, RADIX_DEC, 1'b0);
		add_number(1'b1, '1, 6'd16, 1'b0);
		add_number(1'b1, 64'h8000_0000_0000_0000, RADIX_MIN, 1'b1);
		add_number(1'b0, 64'd35, RADIX_MAX, 1'b0);
		add_number(1'b0, 64'd36, RADIX_MAX, 1'b0);
		add_number(1'b0, 64'd9, RADIX_DEC, 1'b0);
		add_number(1'b0, 64'd10, 6'd16, 1'b0);
		add_number(1'b0, 64'd5, 6'd0, 1'b0);
		add_number(1'b0, 64'd5, 6'd1, 1'b0);
		add_number(1'b0, 64'd35, 6'd37, 1'b0);
		add_number(1'b0, 64'hffff_ffff, 6'd63, 1'b0);
		add_number(1'b1, -64'sd5, 6'd63, 1'b0);
		add_number(1'b1, -64'sd12345, RADIX_DEC, 1'b0);
		add_number(1'b1, 64'd5, RADIX_DEC, 1'b0);
		add_number(1'b0, 64'hdead_beef_0123_4567, 6'd16, 1'b0);
		add_number(1'b0, 64'h8000_0000_0000_0000, 6'd8, 1'b0);

		for (i = 0; i < RANDOM_NUMBERS; i++) begin
			if (i % 10 == 0)
				fill_burst = ($urandom_range(0, 3) == 0);
			v = {$urandom, $urandom};
			case ($urandom_range(0, 7))
				0, 1, 2, 3: v = v >> $urandom_range(0, 63);
				4: begin
					case ($urandom_range(0, 3))
						0: v = 64'd0;
						1: v = '1;
						2: v = 64'h8000_0000_0000_0000;
						default: v = 64'h7fff_ffff_ffff_ffff;
					endcase
				end
				default: ;
			endcase
			case ($urandom_range(0, 9))
				0: r = RADIX_W'($urandom_range(0, 1));
				1: r = RADIX_W'($urandom_range(37, 63));
				2: r = RADIX_DEC;
				3: r = RADIX_MIN;
				default: r = RADIX_W'($urandom_range(2, 36));
			endcase
			m = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 4) == 0) begin
				m = 1'b1;
				r = RADIX_DEC;
			end
			add_number(m, v, r, i == RANDOM_NUMBERS / 2);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (numbers_done != numbers_queued)
			@(posedge clk);
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run converted %0d numbers (%0d negative decimal, %0d radix code out of range)",
			numbers_done, neg_decimal_done, odd_radix_done);
		$display("checked %0d characters, %0d mismatches", chars_done, error_count);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/itoa_pkg.sv
rtl/itoa_in_if.sv
rtl/itoa_out_if.sv
rtl/integer_to_ascii_radix.sv
sim/integer_to_ascii_radix_tb.sv
